// ===== sv/pidl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pidl_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W  = 2;
    localparam int POS_W = 5;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
        logic rot;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/pidl_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pidl_cmd_if;
    logic                              valid;
    logic                              ready;
    logic        [pidl_pkg::OP_W-1:0]  opcode;
    logic        [pidl_pkg::POS_W-1:0] position;
    logic signed [pidl_pkg::VAL_W-1:0] value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

`default_nettype wire

// ===== sv/pidl_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pidl_rsp_if;
    logic                              valid;
    logic                              ready;
    logic        [pidl_pkg::ST_W-1:0]  status;
    logic signed [pidl_pkg::VAL_W-1:0] value_out;
    logic        [pidl_pkg::POS_W-1:0] slot_out;
    logic                              last;

    modport source (output valid, output status, output value_out, output slot_out,
                    output last, input ready);
    modport sink   (input valid, input status, input value_out, input slot_out,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== sv/pidl_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pidl_cell #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  wire                                      clk,
    input  wire pidl_pkg::cell_ctl_t                 ctl,
    input  wire        [pidl_pkg::POS_W-1:0]         pos0,
    input  wire        [$clog2(DEPTH+1)-1:0]         tail,
    input  wire signed [pidl_pkg::VAL_W-1:0]         din,
    input  wire signed [pidl_pkg::VAL_W-1:0]         prev,
    input  wire signed [pidl_pkg::VAL_W-1:0]         next,
    input  wire signed [pidl_pkg::VAL_W-1:0]         head,
    output logic signed [pidl_pkg::VAL_W-1:0]        q
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W) + 1;
    localparam logic [CMPW-1:0] IDX_V = CMPW'(IDX);

    logic [CMPW-1:0]                  pos_x;
    logic [CMPW-1:0]                  tail_x;
    logic signed [pidl_pkg::VAL_W-1:0] data_reg;
    logic signed [pidl_pkg::VAL_W-1:0] data_next;

    assign pos_x  = CMPW'(pos0);
    assign tail_x = CMPW'(tail);

    always_comb
    begin
        data_next = data_reg;
        if (ctl.ins)
        begin
            if (IDX_V == pos_x)
                data_next = din;
            else if (IDX_V > pos_x)
                data_next = prev;
        end
        else if (ctl.del)
        begin
            if (IDX_V >= pos_x)
                data_next = next;
        end
        else if (ctl.rot)
        begin
            // dump rotates the row; the tail picks up the old head
            if (IDX_V == tail_x)
                data_next = head;
            else
                data_next = next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

// ===== sv/positional_insert_delete_list_top.sv =====
// Insert, delete, no-op and rejected requests: one result, registered, in the cycle after transfer.
// Insert and delete: a new request every cycle while the result side keeps up.
// Dump of N entries: N results, one per cycle while the result side keeps up, set by the
// rotation of the cell row; the next request is taken with the final dump result.
// Reset (rst_n, async active low) empties the list; entry storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_list_top #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEFAULT
) (
    input wire          clk,
    input wire          rst_n,
    pidl_cmd_if.sink    cmd,
    pidl_rsp_if.source  rsp
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > pidl_pkg::POS_W) ? CW : pidl_pkg::POS_W) + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                               state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [CW-1:0]                      idx_reg, idx_next;
    logic                               ovalid_reg, ovalid_next;
    logic [pidl_pkg::ST_W-1:0]          ost_reg, ost_next;
    logic signed [pidl_pkg::VAL_W-1:0]  oval_reg, oval_next;
    logic [pidl_pkg::POS_W-1:0]         oslot_reg, oslot_next;
    logic                               olast_reg, olast_next;

    pidl_pkg::cell_ctl_t                ctl;
    logic [pidl_pkg::POS_W-1:0]         pos0;
    logic [CW-1:0]                      tail;
    logic signed [pidl_pkg::VAL_W-1:0]  cell_q [DEPTH];

    logic              out_free;
    logic              accept;
    logic              emit;
    logic              empty;
    logic              full;
    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   cnt_x;
    logic [CMPW-1:0]   cnt_inc;
    logic [CMPW-1:0]   cnt_dec;
    logic [CMPW-1:0]   idx_inc;

    assign out_free  = !ovalid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign pos_x   = CMPW'(cmd.position);
    assign cnt_x   = CMPW'(count_reg);
    assign cnt_inc = cnt_x + CMPW'(1);
    assign cnt_dec = cnt_x - CMPW'(1);
    assign idx_inc = CMPW'(idx_reg) + CMPW'(1);
    assign empty   = (count_reg == '0);
    assign full    = (cnt_x >= CMPW'(DEPTH));
    assign tail    = count_reg - CW'(1);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        pos0       = '0;
        emit       = 1'b0;
        ost_next   = pidl_pkg::ST_OK;
        oval_next  = '0;
        oslot_next = cnt_x[pidl_pkg::POS_W-1:0];
        olast_next = 1'b1;

        if (state_reg == S_DUMP)
        begin
            if (out_free)
            begin
                emit       = 1'b1;
                ctl.rot    = 1'b1;
                oval_next  = cell_q[0];
                oslot_next = idx_inc[pidl_pkg::POS_W-1:0];
                olast_next = (idx_inc == cnt_x);
                idx_next   = idx_inc[CW-1:0];
                if (idx_inc == cnt_x)
                    state_next = S_IDLE;
            end
        end
        else if (accept)
        begin
            emit = 1'b1;
            case (cmd.opcode)
                pidl_pkg::OP_INSERT:
                begin
                    if (empty)
                    begin
                        ctl.ins    = 1'b1;
                        count_next = CW'(1);
                        oslot_next = cnt_inc[pidl_pkg::POS_W-1:0];
                    end
                    else if (full)
                        ost_next = pidl_pkg::ST_FULL;
                    else if (cmd.position == '0 || pos_x > cnt_inc)
                        ost_next = pidl_pkg::ST_BADPOS;
                    else
                    begin
                        ctl.ins    = 1'b1;
                        pos0       = cmd.position - pidl_pkg::POS_W'(1);
                        count_next = cnt_inc[CW-1:0];
                        oslot_next = cnt_inc[pidl_pkg::POS_W-1:0];
                    end
                end
                pidl_pkg::OP_DELETE:
                begin
                    if (empty)
                    begin
                        ost_next   = pidl_pkg::ST_EMPTY;
                        oslot_next = '0;
                    end
                    else if (cmd.position == '0 || pos_x > cnt_x)
                        ost_next = pidl_pkg::ST_BADPOS;
                    else
                    begin
                        ctl.del    = 1'b1;
                        pos0       = cmd.position - pidl_pkg::POS_W'(1);
                        count_next = cnt_dec[CW-1:0];
                        oslot_next = cnt_dec[pidl_pkg::POS_W-1:0];
                    end
                end
                pidl_pkg::OP_DUMP:
                begin
                    if (empty)
                    begin
                        ost_next   = pidl_pkg::ST_EMPTY;
                        oslot_next = '0;
                    end
                    else
                    begin
                        ctl.rot    = 1'b1;
                        oval_next  = cell_q[0];
                        oslot_next = pidl_pkg::POS_W'(1);
                        olast_next = (count_reg == CW'(1));
                        idx_next   = CW'(1);
                        if (count_reg != CW'(1))
                            state_next = S_DUMP;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (emit)
            ovalid_next = 1'b1;
        else if (rsp.ready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [pidl_pkg::VAL_W-1:0] prev_w;
            logic signed [pidl_pkg::VAL_W-1:0] next_w;

            if (gi == 0)
            begin : g_first
                assign prev_w = '0;
            end
            else
            begin : g_mid_prev
                assign prev_w = cell_q[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign next_w = '0;
            end
            else
            begin : g_mid_next
                assign next_w = cell_q[gi+1];
            end

            pidl_cell #(
                .DEPTH (DEPTH),
                .IDX   (gi)
            ) u_cell (
                .clk  (clk),
                .ctl  (ctl),
                .pos0 (pos0),
                .tail (tail),
                .din  (cmd.value),
                .prev (prev_w),
                .next (next_w),
                .head (cell_q[0]),
                .q    (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ost_reg   <= ost_next;
            oval_reg  <= oval_next;
            oslot_reg <= oslot_next;
            olast_reg <= olast_next;
        end
    end

    assign rsp.valid     = ovalid_reg;
    assign rsp.status    = ost_reg;
    assign rsp.value_out = oval_reg;
    assign rsp.slot_out  = oslot_reg;
    assign rsp.last      = olast_reg;

endmodule

`default_nettype wire
